[hdl/indexed_list_engine_core_defines.svh]
// assertion macros for the indexed list engine checker
// no dependencies; taken in by the checker file only
`ifndef INDEXED_LIST_ENGINE_CORE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define ILEC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ilec check failed");

// next-cycle implication, sampled on aclk, off during reset
`define ILEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ilec check failed");

`endif

[hdl/ilec_pkg.sv]
// shared constants of the indexed list engine: command and status codes, bus widths
// no dependencies
package ilec_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 4;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [CMD_W-1:0] OP_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] OP_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] OP_GET    = 3'd2;
    localparam logic [CMD_W-1:0] OP_SET    = 3'd3;
    localparam logic [CMD_W-1:0] OP_REMOVE = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

[hdl/ilec_store.sv]
// element store of the indexed list engine: one write port, one registered read port
// depends on ilec_pkg for the word width
module ilec_store #(
    parameter int DEPTH = ilec_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [ilec_pkg::WORD_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [ilec_pkg::WORD_W-1:0] rd_data
);

    logic [ilec_pkg::WORD_W-1:0] mem [DEPTH];
    logic [ilec_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/ilec_step.sv]
// shared index unit: steps the move index by one and decides whether another move remains
// depends on ilec_pkg for the position width
module ilec_step #(
    parameter int AW = 4,
    parameter int CW = 5
) (
    input  logic                       dir_up,
    input  logic [AW-1:0]              idx,
    input  logic [ilec_pkg::POS_W-1:0] pos,
    input  logic [CW-1:0]              count,
    output logic [AW-1:0]              nb,
    output logic                       more
);

    localparam int LW = CW + ilec_pkg::POS_W + 1;

    logic [AW:0]   nb_w;
    logic [LW-1:0] lhs;
    logic [LW-1:0] rhs;

    always_comb begin
        if (dir_up) begin
            nb_w = {1'b0, idx} + (AW+1)'(1);
            lhs  = LW'(nb_w);
            rhs  = LW'(count);
        end else begin
            nb_w = {1'b0, idx} - (AW+1)'(1);
            lhs  = LW'(pos);
            rhs  = LW'(idx);
        end
    end

    // remove: idx+1 < count, insert: pos < idx
    assign more = lhs < rhs;
    assign nb   = nb_w[AW-1:0];

endmodule

[hdl/indexed_list_engine_core.sv]
// top level of the indexed list engine: command sequencer, count and result register
// depends on ilec_pkg, ilec_store and ilec_step
//
//  channel | dir | beat content (tdata, lowest bit up)
//  s_      | in  | command[2:0], position[6:3], item_value[38:7], pad[39]
//  m_      | out | read_value[31:0], status[33:32], entry_count[38:34], pad[39]
//
//  append, set and bad commands: DECODE then OUT; get: DECODE, GETW, then OUT
//  insert and remove: DECODE, then LOOP and MOVE once per entry moved, a registered read
//  then a write per move, and a last LOOP before OUT
//  s_tready is high only while the sequencer is idle; a held result beat stalls the
//  sequencer only when the next result is ready before the held beat is taken
//  synchronous reset empties the list; store contents are not cleared
module indexed_list_engine_core #(
    parameter int CAPACITY = ilec_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // command, position, item_value, zero pad
    input  logic [ilec_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_value, status, entry_count, zero pad
    output logic [ilec_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + ilec_pkg::POS_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_LOOP   = 6'b000100,
        S_MOVE   = 6'b001000,
        S_GETW   = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [ilec_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [ilec_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [ilec_pkg::WORD_W-1:0]  val_reg, val_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [ilec_pkg::WORD_W-1:0]  res_rd_reg, res_rd_next;
    logic [ilec_pkg::STAT_W-1:0]  res_st_reg, res_st_next;
    logic                         m_valid_reg, m_valid_next;
    logic [ilec_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [ilec_pkg::WORD_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [ilec_pkg::WORD_W-1:0] rd_data;

    logic          dir_up;
    logic [AW-1:0] nb;
    logic          more;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic          pos_ok;
    logic          full;
    logic [CW+4:0] cnt_w;
    logic          s_accept;

    assign pos_x    = XW'(pos_reg);
    assign cnt_x    = XW'(count_reg);
    assign pos_ok   = pos_x < cnt_x;
    assign full     = count_reg == CW'(CAPACITY);
    assign cnt_w    = (CW+5)'(count_reg);
    assign dir_up   = cmd_reg == ilec_pkg::OP_REMOVE;
    assign s_tready = state_reg == S_IDLE;
    assign s_accept = s_tvalid && s_tready;

    ilec_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ilec_step #(
        .AW (AW),
        .CW (CW)
    ) u_step (
        .dir_up (dir_up),
        .idx    (idx_reg),
        .pos    (pos_reg),
        .count  (count_reg),
        .nb     (nb),
        .more   (more)
    );

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        res_rd_next  = res_rd_reg;
        res_st_next  = res_st_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = val_reg;
        rd_en        = 1'b0;
        rd_addr      = nb;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    cmd_next   = s_tdata[2:0];
                    pos_next   = s_tdata[6:3];
                    val_next   = s_tdata[38:7];
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_rd_next = '0;
                res_st_next = ilec_pkg::STAT_OK;
                state_next  = S_OUT;
                unique case (cmd_reg)
                    ilec_pkg::OP_APPEND: begin
                        if (full) begin
                            res_st_next = ilec_pkg::STAT_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                    ilec_pkg::OP_INSERT: begin
                        if (!pos_ok) begin
                            res_st_next = ilec_pkg::STAT_INDEX;
                        end else if (full) begin
                            res_st_next = ilec_pkg::STAT_FULL;
                        end else begin
                            idx_next   = count_reg[AW-1:0];
                            state_next = S_LOOP;
                        end
                    end
                    ilec_pkg::OP_GET: begin
                        if (!pos_ok) begin
                            res_st_next = ilec_pkg::STAT_INDEX;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = pos_x[AW-1:0];
                            state_next = S_GETW;
                        end
                    end
                    ilec_pkg::OP_SET: begin
                        if (!pos_ok) begin
                            res_st_next = ilec_pkg::STAT_INDEX;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = pos_x[AW-1:0];
                        end
                    end
                    ilec_pkg::OP_REMOVE: begin
                        if (!pos_ok) begin
                            res_st_next = ilec_pkg::STAT_INDEX;
                        end else begin
                            idx_next   = pos_x[AW-1:0];
                            state_next = S_LOOP;
                        end
                    end
                    default: begin
                        res_st_next = ilec_pkg::STAT_OK;
                    end
                endcase
            end
            S_LOOP: begin
                if (more) begin
                    rd_en      = 1'b1;
                    state_next = S_MOVE;
                end else if (dir_up) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_OUT;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = S_OUT;
                end
            end
            S_MOVE: begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                idx_next   = nb;
                state_next = S_LOOP;
            end
            S_GETW: begin
                res_rd_next = rd_data;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, cnt_w[4:0], res_st_reg, res_rd_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        res_rd_reg <= res_rd_next;
        res_st_reg <= res_st_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[hdl/ilec_checker.sv]
// port-level checks of the indexed list engine, bound to the top level
// depends on ilec_pkg and indexed_list_engine_core_defines.svh
`include "indexed_list_engine_core_defines.svh"

module ilec_checker #(
    parameter int CAPACITY = ilec_pkg::CAPACITY_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [ilec_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ilec_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam logic [ilec_pkg::COUNT_W-1:0] CAP_MASKED = ilec_pkg::COUNT_W'(CAPACITY);

    logic [ilec_pkg::STAT_W-1:0] m_status;

    assign m_status = m_tdata[33:32];

    // stalled result beat holds
    `ILEC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // s_tready is low once a command is accepted
    `ILEC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // no value leaks out of a failed command
    `ILEC_ASSERT_NOW(a_rd_zero_on_err, m_tvalid && m_status != ilec_pkg::STAT_OK,
                     m_tdata[31:0] == '0)

    // full is only reported at capacity
    `ILEC_ASSERT_NOW(a_full_count, m_tvalid && m_status == ilec_pkg::STAT_FULL,
                     m_tdata[38:34] == CAP_MASKED)

    // no status beyond full and no pad bit ever appear
    `ILEC_ASSERT_NOW(a_status_code, m_tvalid,
                     m_status <= ilec_pkg::STAT_FULL && m_tdata[39] == 1'b0)

endmodule

bind indexed_list_engine_core ilec_checker #(.CAPACITY(CAPACITY)) u_ilec_checker (.*);

[tb/indexed_list_engine_core_checker.sv]
// checker for the indexed list engine: keeps its own copy of the list, predicts each
// result beat and compares it field by field; depends on ilec_pkg only
module indexed_list_engine_core_checker
    import ilec_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatch_count,
    output int                   results_pending
);

    // packed so that read_value lands in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic [STAT_W-1:0]  status;
        logic [WORD_W-1:0]  read_value;
    } list_outcome_t;

    logic [WORD_W-1:0] list_words [CAPACITY_DEF];
    int unsigned       list_len;
    list_outcome_t     pending_outcomes [$];
    int                fail_total;
    int                depth;

    assign mismatch_count  = fail_total;
    assign results_pending = depth;

    initial begin
        fail_total = 0;
        depth      = 0;
        list_len   = 0;
    end

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        if (fail_total < 30) begin
            $display("%0t %s: got %h, expected %h", $time, what, got, want);
        end
        fail_total++;
    endtask

    function automatic list_outcome_t apply_list_command(input logic [CMD_W-1:0] cmd,
                                                         input logic [POS_W-1:0] pos,
                                                         input logic [WORD_W-1:0] word);
        list_outcome_t o;
        int unsigned   i;
        o.read_value = '0;
        o.status     = STAT_OK;
        case (cmd)
            OP_APPEND: begin
                if (list_len >= CAPACITY_DEF) begin
                    o.status = STAT_FULL;
                end else begin
                    list_words[list_len] = word;
                    list_len++;
                end
            end
            OP_INSERT, OP_GET, OP_SET, OP_REMOVE: begin
                if (pos >= list_len) begin
                    o.status = STAT_INDEX;
                end else if (cmd == OP_INSERT) begin
                    if (list_len >= CAPACITY_DEF) begin
                        o.status = STAT_FULL;
                    end else begin
                        for (i = list_len; i > pos; i--) begin
                            list_words[i] = list_words[i-1];
                        end
                        list_words[pos] = word;
                        list_len++;
                    end
                end else if (cmd == OP_GET) begin
                    o.read_value = list_words[pos];
                end else if (cmd == OP_SET) begin
                    list_words[pos] = word;
                end else begin
                    for (i = pos; i + 1 < list_len; i++) begin
                        list_words[i] = list_words[i+1];
                    end
                    list_len--;
                end
            end
            default: begin
            end
        endcase
        o.entry_count = COUNT_W'(list_len);
        return o;
    endfunction

    always @(posedge aclk) begin
        list_outcome_t got;
        list_outcome_t want;
        if (!aresetn) begin
            list_len = 0;
            pending_outcomes.delete();
            depth = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = list_outcome_t'(m_tdata[COUNT_W+STAT_W+WORD_W-1:0]);
                if (pending_outcomes.size() == 0) begin
                    report_mismatch("result beat with none pending", got.read_value, '0);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got.read_value !== want.read_value) begin
                        report_mismatch("read_value", got.read_value, want.read_value);
                    end
                    if (got.status !== want.status) begin
                        report_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
                    end
                    if (got.entry_count !== want.entry_count) begin
                        report_mismatch("entry_count", WORD_W'(got.entry_count),
                                        WORD_W'(want.entry_count));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_outcomes.push_back(apply_list_command(
                    s_tdata[CMD_W-1:0],
                    s_tdata[CMD_W+POS_W-1:CMD_W],
                    s_tdata[CMD_W+POS_W+WORD_W-1:CMD_W+POS_W]));
            end
            depth = pending_outcomes.size();
        end
    end

endmodule

[tb/indexed_list_engine_core_test.sv]
// top of the indexed list engine test: clock, reset, command stream and result back-pressure
// depends on ilec_pkg, indexed_list_engine_core and indexed_list_engine_core_checker
module indexed_list_engine_core_test;
    import ilec_pkg::*;

    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_CHURN} traffic_mode_t;

    localparam logic [CMD_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam int BLOCK_LEN  = 40;
    localparam int BLOCK_CNT  = 18;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   mismatch_count;
    int                   results_pending;
    bit                   steady_flow;

    indexed_list_engine_core #(.CAPACITY(CAPACITY_DEF)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    indexed_list_engine_core_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #6_000_000;
        $display("indexed_list_engine_core: mismatch");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, 3));
        return POS_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input traffic_mode_t mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2) return OP_UNUSED_LO + CMD_W'($urandom_range(0, 2));
        case (mode)
            MODE_GROW: begin
                if (r < 55) return OP_APPEND;
                if (r < 80) return OP_INSERT;
                if (r < 88) return OP_GET;
                if (r < 95) return OP_SET;
                return OP_REMOVE;
            end
            MODE_SHRINK: begin
                if (r < 50) return OP_REMOVE;
                if (r < 70) return OP_GET;
                if (r < 85) return OP_SET;
                if (r < 93) return OP_APPEND;
                return OP_INSERT;
            end
            default: begin
                if (r < 22) return OP_APPEND;
                if (r < 42) return OP_INSERT;
                if (r < 62) return OP_GET;
                if (r < 80) return OP_SET;
                return OP_REMOVE;
            end
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] word);
        int unsigned gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, word, pos, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // result side back-pressure
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!steady_flow) stall_left = pick_gap();
            end
        end
    end

    initial begin
        traffic_mode_t mode;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        aresetn     = 1'b0;
        steady_flow = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // empty list: every indexed command is out of range
        send_command(OP_GET,    4'd0,  32'h1111_1111);
        send_command(OP_REMOVE, 4'd0,  32'h2222_2222);
        send_command(OP_INSERT, 4'd0,  32'h3333_3333);
        send_command(OP_SET,    4'd15, 32'h4444_4444);
        send_command(OP_APPEND, 4'd15, 32'h8000_0000);
        send_command(OP_APPEND, 4'd0,  32'h7fff_ffff);
        send_command(OP_APPEND, 4'd0,  32'hffff_ffff);
        send_command(OP_APPEND, 4'd0,  32'h0000_0000);
        send_command(OP_INSERT, 4'd0,  32'h1234_5678);
        // insert at the end is rejected
        send_command(OP_INSERT, 4'd5,  32'hdead_beef);
        send_command(OP_INSERT, 4'd4,  32'ha5a5_a5a5);
        send_command(OP_GET,    4'd0,  32'h0000_0000);
        send_command(OP_GET,    4'd5,  32'hffff_ffff);
        send_command(OP_SET,    4'd2,  32'h5a5a_5a5a);
        send_command(OP_GET,    4'd2,  32'h0000_0000);
        send_command(OP_REMOVE, 4'd0,  32'h0000_0000);
        send_command(OP_REMOVE, 4'd4,  32'h0000_0000);
        send_command(OP_UNUSED_LO,        4'd15, 32'hffff_ffff);
        send_command(OP_UNUSED_LO + 3'd1, 4'd3,  32'h8000_0000);
        send_command(OP_UNUSED_LO + 3'd2, 4'd0,  32'h7fff_ffff);
        send_command(OP_GET,    4'd15, 32'h0000_0000);
        send_command(OP_GET,    4'd3,  32'h0000_0000);

        for (int b = 0; b < BLOCK_CNT; b++) begin
            if (b == 0) begin
                mode = MODE_GROW;
            end else if (b == 1) begin
                mode = MODE_SHRINK;
            end else begin
                mode = traffic_mode_t'($urandom_range(0, 2));
            end
            steady_flow = (b % 5 == 3);
            if (b == 6) begin
                s_tvalid <= 1'b0;
                while (results_pending != 0) @(negedge aclk);
            end
            for (int k = 0; k < BLOCK_LEN; k++) begin
                send_command(pick_command(mode), pick_position(), pick_word());
            end
        end
        s_tvalid <= 1'b0;
        steady_flow = 1'b0;

        while (results_pending != 0) @(negedge aclk);
        repeat (2 * CAPACITY_DEF + 8) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("indexed_list_engine_core: match");
        end else begin
            $display("indexed_list_engine_core: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/ilec_pkg.sv
hdl/ilec_store.sv
hdl/ilec_step.sv
hdl/indexed_list_engine_core.sv
hdl/ilec_checker.sv
tb/indexed_list_engine_core_checker.sv
tb/indexed_list_engine_core_test.sv
